// ===== hdl/wegm_pkg.sv =====
// ---------------------------------------------------------------------------
// wegm_pkg
// shared types, codes and the quarter-wave sine generator
// ---------------------------------------------------------------------------
package wegm_pkg;

   localparam int PHASE_BITS = 24;

   // envelope modes
   localparam logic [2:0] MODE_RECT      = 3'd0;
   localparam logic [2:0] MODE_PARABOLA  = 3'd1;
   localparam logic [2:0] MODE_HALF_SINE = 3'd2;
   localparam logic [2:0] MODE_FULL_SINE = 3'd3;
   localparam logic [2:0] MODE_SINE_SQ   = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_START  = 2'd0;
   localparam logic [1:0] CSR_LENGTH = 2'd1;
   localparam logic [1:0] CSR_MODE   = 2'd2;
   localparam logic [1:0] CSR_AMP    = 2'd3;

   localparam logic [31:0] LENGTH_RESET = 32'd65536;
   localparam logic signed [33:0] CLAMP_LOW = -34'sd65535;
   localparam logic signed [33:0] ONE_Q16 = 34'sd65536;

   // q30 polynomial coefficients
   localparam logic [63:0] SIN_C1 = 64'd1686629713;
   localparam logic [63:0] SIN_C3 = 64'd693598668;
   localparam logic [63:0] SIN_C5 = 64'd85569306;
   localparam logic [63:0] SIN_C7 = 64'd5026995;
   localparam logic [63:0] SIN_C9 = 64'd172273;

   // one divider lane: partial remainder and quotient plus side data
   typedef struct packed {
      logic        valid;
      logic        in_win;
      logic [23:0] rate;
      logic [31:0] rem;
      logic [23:0] quo;
   } wegm_lane_type;

   // sin(pi/2 x), x in q30, result q16; used only on constants
   function automatic logic [16:0] quarter_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x2 = (x * x) >> 30;
      t  = SIN_C9;
      t  = SIN_C7 - ((x2 * t) >> 30);
      t  = SIN_C5 - ((x2 * t) >> 30);
      t  = SIN_C3 - ((x2 * t) >> 30);
      t  = SIN_C1 - ((x2 * t) >> 30);
      s  = (x * t) >> 30;
      s  = (s + 64'd8192) >> 14;
      if (s > 64'd65536) begin
         s = 64'd65536;
      end
      return s[16:0];
   endfunction

endpackage

// ===== hdl/wegm_div_cell.sv =====
// ---------------------------------------------------------------------------
// wegm_div_cell
// one restoring divide step: shift remainder, compare, subtract, emit bit
// ---------------------------------------------------------------------------
module wegm_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [31:0]            len,
   input  wegm_pkg::wegm_lane_type lane_in,
   output wegm_pkg::wegm_lane_type lane_out
);
   import wegm_pkg::*;

   wegm_lane_type lane_ff;
   wegm_lane_type lane_step_in;
   logic [32:0]   shifted;
   logic [31:0]   diff;
   logic          ge;

   // the partial remainder stays below len, so the difference fits 32 bits
   assign shifted = {lane_in.rem, 1'b0};
   assign diff    = shifted[31:0] - len;
   assign ge      = shifted >= {1'b0, len};

   always_comb begin
      lane_step_in      = lane_in;
      lane_step_in.rem  = ge ? diff : shifted[31:0];
      lane_step_in.quo  = {lane_in.quo[22:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (en) begin
         lane_ff <= lane_step_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

// ===== hdl/wegm_sine_rom.sv =====
// ---------------------------------------------------------------------------
// wegm_sine_rom
// quarter-wave sine table with quadrant folding, registered read
// ---------------------------------------------------------------------------
module wegm_sine_rom #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [SINE_TABLE_BITS-1:0] idx,
   output logic [16:0]                mag,
   output logic                       neg
);
   import wegm_pkg::*;

   localparam int QBITS   = SINE_TABLE_BITS - 2;
   localparam int QUARTER = 1 << QBITS;
   localparam int QN      = QUARTER + 1;

   logic [16:0]          tbl [QN];
   logic [1:0]           quad;
   logic [QBITS-1:0]     r;
   logic [QBITS:0]       k;
   logic [16:0]          mag_ff;
   logic                 neg_ff;

   for (genvar g = 0; g < QN; g++) begin : g_tbl
      assign tbl[g] = quarter_sine(64'(g) << (30 - QBITS));
   end

   assign quad = idx[SINE_TABLE_BITS-1 -: 2];
   assign r    = idx[QBITS-1:0];
   assign k    = quad[0] ? ((QBITS+1)'(QUARTER) - {1'b0, r}) : {1'b0, r};

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= tbl[k];
         neg_ff <= quad[1];
      end
   end

   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule

// ===== hdl/windowed_envelope_gain_modulator.sv =====
// pipeline: 1 window stage, 24 divider cells, rom/parabola, envelope, scale, factor,
//   output product
// throughput: one beat per cycle; the whole pipe advances while the output
//   register is empty or being taken
// reset: synchronous, active high; clears all stage valids and the configuration registers
// ---------------------------------------------------------------------------
// windowed_envelope_gain_modulator
// rate modulation by a windowed envelope, pipelined through a divider chain
// ---------------------------------------------------------------------------
module windowed_envelope_gain_modulator #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_time_now,
   input  logic [23:0] req_rate_in,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_rate_out,
   output logic        rsp_in_window,
   output logic        rsp_saturated,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import wegm_pkg::*;

   localparam int NCELL = PHASE_BITS;

   // configuration registers
   logic [31:0]        start_ff;
   logic [31:0]        len_ff;
   logic [2:0]         mode_ff;
   logic signed [15:0] amp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         len_ff   <= LENGTH_RESET;
         mode_ff  <= MODE_RECT;
         amp_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START:  start_ff <= csr_wdata;
            CSR_LENGTH: len_ff   <= csr_wdata;
            CSR_MODE:   mode_ff  <= csr_wdata[2:0];
            CSR_AMP:    amp_ff   <= csr_wdata[15:0];
            default:    ;
         endcase
      end
   end

   // single stall for the whole pipe, set by the output register
   logic en;
   logic out_valid_ff;
   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   // window test and offset
   logic [31:0]   diff;
   logic          win;
   wegm_lane_type s0_in;
   wegm_lane_type s0_ff;
   wegm_lane_type lane [0:NCELL];

   // offset only matters inside the window, where it cannot wrap
   assign diff = req_time_now - start_ff;
   assign win  = (req_time_now > start_ff)
              && ({1'b0, req_time_now} < ({1'b0, start_ff} + {1'b0, len_ff}))
              && (len_ff != '0);

   always_comb begin
      s0_in.valid  = req_valid;
      s0_in.in_win = win;
      s0_in.rate   = req_rate_in;
      s0_in.rem    = diff;
      s0_in.quo    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (en) begin
         s0_ff <= s0_in;
      end
   end

   assign lane[0] = s0_ff;

   // divider chain: one quotient bit per cell gives the q0.24 phase
   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      wegm_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .len      (len_ff),
         .lane_in  (lane[g]),
         .lane_out (lane[g+1])
      );
   end

   // stage e1: sine rom lookup and parabola product
   logic [23:0]                phase;
   logic [SINE_TABLE_BITS-1:0] rom_idx;
   logic [16:0]                rom_mag;
   logic                       rom_neg;
   logic [48:0]                pp_ff;
   logic                       e1_valid_ff;
   logic                       e1_win_ff;
   logic [23:0]                e1_rate_ff;

   assign phase   = lane[NCELL].quo;
   // full sine uses the top bits, the half-sine family one bit fewer
   assign rom_idx = (mode_ff == MODE_FULL_SINE) ? phase[23 -: SINE_TABLE_BITS]
                  : {1'b0, phase[23 -: SINE_TABLE_BITS-1]};

   wegm_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_rom (
      .clock (clock),
      .en    (en),
      .idx   (rom_idx),
      .mag   (rom_mag),
      .neg   (rom_neg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (en) begin
         e1_valid_ff <= lane[NCELL].valid;
         e1_win_ff   <= lane[NCELL].in_win;
         e1_rate_ff  <= lane[NCELL].rate;
         pp_ff       <= 49'(phase) * (49'(25'd16777216) - 49'(phase));
      end
   end

   // stage e2: envelope select, zero outside the window so the factor is one
   logic [33:0]        sq;
   logic signed [17:0] env_in;
   logic signed [17:0] env_ff;
   logic               e2_valid_ff;
   logic               e2_win_ff;
   logic [23:0]        e2_rate_ff;

   assign sq = 34'(rom_mag) * 34'(rom_mag);

   always_comb begin
      case (mode_ff)
         MODE_PARABOLA:  env_in = 18'(pp_ff >> 30);
         MODE_HALF_SINE,
         MODE_FULL_SINE: env_in = rom_neg ? -$signed({1'b0, rom_mag})
                                          : $signed({1'b0, rom_mag});
         MODE_SINE_SQ:   env_in = $signed(sq[33:16]);
         default:        env_in = 18'sd65536;
      endcase
      if (!e1_win_ff) begin
         env_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else if (en) begin
         e2_valid_ff <= e1_valid_ff;
         e2_win_ff   <= e1_win_ff;
         e2_rate_ff  <= e1_rate_ff;
         env_ff      <= env_in;
      end
   end

   // stage e3: depth scaling
   logic signed [33:0] m_ff;
   logic               e3_valid_ff;
   logic               e3_win_ff;
   logic [23:0]        e3_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e3_valid_ff <= 1'b0;
      end else if (en) begin
         e3_valid_ff <= e2_valid_ff;
         e3_win_ff   <= e2_win_ff;
         e3_rate_ff  <= e2_rate_ff;
         m_ff        <= 34'(env_ff) * 34'(amp_ff);
      end
   end

   // stage e4: floor to q16, clamp, add one
   logic signed [33:0] v;
   logic signed [33:0] f_sum;
   logic [19:0]        f_ff;
   logic               e4_valid_ff;
   logic               e4_win_ff;
   logic [23:0]        e4_rate_ff;

   always_comb begin
      v = m_ff >>> 12;
      if (v < CLAMP_LOW) begin
         v = CLAMP_LOW;
      end
      f_sum = ONE_Q16 + v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e4_valid_ff <= 1'b0;
      end else if (en) begin
         e4_valid_ff <= e3_valid_ff;
         e4_win_ff   <= e3_win_ff;
         e4_rate_ff  <= e3_rate_ff;
         f_ff        <= f_sum[19:0];
      end
   end

   // output stage: product and saturation
   logic [43:0] prod;
   logic        sat;
   logic [23:0] rate_out_ff;
   logic        in_win_ff;
   logic        sat_ff;

   assign prod = 44'(e4_rate_ff) * 44'(f_ff);
   assign sat  = prod[43:40] != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= e4_valid_ff;
         in_win_ff    <= e4_win_ff;
         sat_ff       <= sat;
         rate_out_ff  <= sat ? '1 : prod[39:16];
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_rate_out  = rate_out_ff;
   assign rsp_in_window = in_win_ff;
   assign rsp_saturated = sat_ff;

`ifndef SYNTH
   // a pass-through beat never reports clipping
   a_no_sat_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_in_window || !rsp_saturated))
      else $error("saturated set outside window");

   // input side is open exactly when the output register can move
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready out of step with output stage");

   // pipe comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a clipped beat carries the maximum rate
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_rate_out == 24'hFFFFFF))
      else $error("saturated beat not at maximum");
`endif

endmodule
